// ===== sv/request_tag_manager_top_macros.svh =====
// Assertion macros shared by the checkers of the request tag manager.
// Depends on nothing; each macro expects clk and arst_n in the enclosing scope.
`ifndef REQUEST_TAG_MANAGER_TOP_MACROS_SVH
`define REQUEST_TAG_MANAGER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rtm_pkg.sv =====
// Package of the request tag manager: sizes, codes and shared types.
// Used by every RTL file of the block; depends on nothing.
package rtm_pkg;

	localparam int NUM_TAGS = 64;
	localparam int TAG_W = $clog2(NUM_TAGS);
	localparam int LINK_W = $clog2(NUM_TAGS + 1);
	localparam int CMD_W = 8;
	localparam int TAG_IN_W = 16;
	localparam int FUNC_W = 2;
	localparam int STATUS_W = 3;
	localparam logic [CMD_W-1:0] CMD_ERROR = CMD_W'(107);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ISSUE = 2'd0,
		FUNC_RELEASE = 2'd1,
		FUNC_RESPONSE = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 3'd0,
		ST_NO_FREE = 3'd1,
		ST_RANGE = 3'd2,
		ST_NOT_PENDING = 3'd3,
		ST_ERROR = 3'd4,
		ST_WRONG_TYPE = 3'd5,
		ST_NOT_ALLOC = 3'd6
	} status_t;

	typedef struct packed {
		logic [LINK_W-1:0] link;
		logic [CMD_W-1:0] cmd;
	} tag_entry_t;

	typedef struct packed {
		logic re;
		logic [TAG_W-1:0] raddr;
		logic we;
		logic [TAG_W-1:0] waddr;
		tag_entry_t wdata;
	} ram_req_t;

endpackage

// ===== sv/rtm_tag_ram.sv =====
// Tag RAM of the request tag manager: one entry per tag, free-list link and command.
// Synchronous write, registered read. Depends on rtm_pkg.
module rtm_tag_ram (
	input logic clk,
	input rtm_pkg::ram_req_t req,
	output rtm_pkg::tag_entry_t rdata
);
	import rtm_pkg::*;

	tag_entry_t mem [NUM_TAGS];
	tag_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/request_tag_manager_top.sv =====
// Top level of the request tag manager: control, flags and free-list head.
// Depends on rtm_pkg and rtm_tag_ram.
//
// An item is taken when start is high and busy is low. The tag RAM entry is read
// at that edge, and in the following cycle the entry is checked, updated and
// written back where the function changes it, so busy is high for one cycle after
// each item and the block cannot take a new item until the last one is through. The
// result is registered with done after that working cycle and is shown for exactly
// one cycle; the receiver cannot stall it. No clearing pass runs after reset: link
// entries never written read as their reset chain through a valid bit per tag.
module request_tag_manager_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [rtm_pkg::FUNC_W-1:0] func,
	input logic [rtm_pkg::CMD_W-1:0] req_cmd,
	input logic [rtm_pkg::TAG_IN_W-1:0] tag_in,
	input logic [rtm_pkg::CMD_W-1:0] resp_cmd,
	output logic done,
	output logic [rtm_pkg::STATUS_W-1:0] status,
	output logic [rtm_pkg::TAG_W-1:0] tag_out,
	output logic [rtm_pkg::CMD_W-1:0] orig_cmd
);
	import rtm_pkg::*;

	logic accept;
	logic valid_s1;
	func_t func_s1;
	logic [CMD_W-1:0] req_cmd_s1;
	logic [TAG_IN_W-1:0] tag_s1;
	logic [CMD_W-1:0] resp_cmd_s1;
	logic [TAG_W-1:0] addr_s1;

	logic [LINK_W-1:0] head_q;
	logic [NUM_TAGS-1:0] link_vld_q;
	logic [NUM_TAGS-1:0] pending_q;
	logic [NUM_TAGS-1:0] alloc_q;

	ram_req_t ram_req;
	tag_entry_t rdata;

	logic [LINK_W-1:0] link_eff;
	logic in_range;
	logic [LINK_W-1:0] head_d;
	logic set_flags;
	logic clr_alloc;
	logic clr_pending;
	status_t status_d;
	logic [TAG_W-1:0] tag_d;
	logic [CMD_W-1:0] orig_d;

	logic done_q;
	status_t status_q;
	logic [TAG_W-1:0] tag_q;
	logic [CMD_W-1:0] orig_q;

	assign busy = valid_s1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func_t'(func);
			req_cmd_s1 <= req_cmd;
			tag_s1 <= tag_in;
			resp_cmd_s1 <= resp_cmd;
			addr_s1 <= ram_req.raddr;
		end
	end

	rtm_tag_ram u_ram (
		.clk(clk),
		.req(ram_req),
		.rdata(rdata)
	);

	assign link_eff = link_vld_q[addr_s1] ? rdata.link
		: LINK_W'({1'b0, addr_s1}) + LINK_W'(1);
	assign in_range = tag_s1 < TAG_IN_W'(NUM_TAGS);

	always_comb begin
		ram_req.re = accept;
		ram_req.raddr = (func_t'(func) == FUNC_ISSUE) ? head_q[TAG_W-1:0] : tag_in[TAG_W-1:0];
		ram_req.we = 1'b0;
		ram_req.waddr = addr_s1;
		ram_req.wdata = rdata;
		head_d = head_q;
		set_flags = 1'b0;
		clr_alloc = 1'b0;
		clr_pending = 1'b0;
		status_d = ST_OK;
		tag_d = '0;
		orig_d = '0;
		case (func_s1)
			FUNC_ISSUE: begin
				if (head_q >= LINK_W'(NUM_TAGS)) begin
					status_d = ST_NO_FREE;
				end else begin
					head_d = link_eff;
					set_flags = 1'b1;
					ram_req.we = valid_s1;
					ram_req.wdata.link = link_eff;
					ram_req.wdata.cmd = req_cmd_s1;
					tag_d = addr_s1;
				end
			end
			FUNC_RELEASE: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else begin
					tag_d = addr_s1;
					if (!alloc_q[addr_s1]) begin
						status_d = ST_NOT_ALLOC;
					end else begin
						ram_req.we = valid_s1;
						ram_req.wdata.link = head_q;
						head_d = LINK_W'({1'b0, addr_s1});
						clr_alloc = 1'b1;
						clr_pending = 1'b1;
					end
				end
			end
			FUNC_RESPONSE: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else begin
					tag_d = addr_s1;
					if (!pending_q[addr_s1]) begin
						status_d = ST_NOT_PENDING;
					end else begin
						clr_pending = 1'b1;
						orig_d = rdata.cmd;
						if (resp_cmd_s1 == CMD_ERROR) begin
							status_d = ST_ERROR;
						end else if ({1'b0, resp_cmd_s1} != {1'b0, rdata.cmd} + 9'd1) begin
							status_d = ST_WRONG_TYPE;
						end
					end
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			link_vld_q <= '0;
			pending_q <= '0;
			alloc_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				head_q <= head_d;
				if (ram_req.we) begin
					link_vld_q[addr_s1] <= 1'b1;
				end
				if (set_flags) begin
					alloc_q[addr_s1] <= 1'b1;
					pending_q[addr_s1] <= 1'b1;
				end
				if (clr_alloc) begin
					alloc_q[addr_s1] <= 1'b0;
				end
				if (clr_pending) begin
					pending_q[addr_s1] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q <= status_d;
			tag_q <= tag_d;
			orig_q <= orig_d;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign tag_out = tag_q;
	assign orig_cmd = orig_q;

endmodule

// ===== sv/rtm_checker.sv =====
// Port-level checker of the request tag manager and its bind to the top level.
// Depends on rtm_pkg and request_tag_manager_top_macros.svh.
`include "request_tag_manager_top_macros.svh"

module rtm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [rtm_pkg::STATUS_W-1:0] status,
	input logic [rtm_pkg::TAG_W-1:0] tag_out,
	input logic [rtm_pkg::CMD_W-1:0] orig_cmd
);
	import rtm_pkg::*;

	`RTM_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy did not follow an accepted item")
	`RTM_ASSERT_NEXT(a_busy_one_cycle, busy, !busy, "busy lasted more than one cycle")
	`RTM_ASSERT_NEXT(a_done_follows, busy, done, "no result followed the working cycle")
	`RTM_ASSERT_SAME(a_orig_zero, done && status != ST_OK && status != ST_ERROR && status != ST_WRONG_TYPE, orig_cmd == '0, "orig_cmd not zero on a failed item")
	`RTM_ASSERT_SAME(a_tag_zero, done && (status == ST_NO_FREE || status == ST_RANGE), tag_out == '0, "tag_out not zero on a rejected item")

endmodule

bind request_tag_manager_top rtm_checker u_rtm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.tag_out(tag_out),
	.orig_cmd(orig_cmd)
);
